// ===== src/sprite_scanline_color_converter_assert.svh =====
// Assertion macros used by the scanline converter walker.
`ifndef SPRITE_SCANLINE_COLOR_CONVERTER_ASSERT_SVH
`define SPRITE_SCANLINE_COLOR_CONVERTER_ASSERT_SVH

// Check a same-cycle implication on clk_i, held off during reset.
`define SSCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sscc assertion failed");

// Check a next-cycle implication on clk_i, held off during reset.
`define SSCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sscc assertion failed");

`endif

// ===== src/sscc_pkg.sv =====
// Types, codes and the color conversion shared by the scanline converter.
package sscc_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;

  // Line status codes
  localparam logic [StatusW-1:0] StatMid   = 2'd0;
  localparam logic [StatusW-1:0] StatDone  = 2'd1;
  localparam logic [StatusW-1:0] StatShort = 2'd2;

  // Position within the coded scanline
  typedef enum logic [2:0] {
    PhPairs   = 3'd0,
    PhTrans   = 3'd1,
    PhIdxCnt  = 3'd2,
    PhIdxSkip = 3'd3,
    PhColCnt  = 3'd4,
    PhColor   = 3'd5,
    PhTail    = 3'd6
  } phase_e;

  // One result item
  typedef struct packed {
    logic [WordW-1:0]   word;
    logic               converted;
    logic [StatusW-1:0] status;
  } result_t;

  // Convert 565 to 555 (dir 0) or 555 to 565 (dir 1)
  function automatic logic [WordW-1:0] conv_word(input logic [WordW-1:0] w,
                                                 input logic dir);
    logic [WordW-1:0] r;
    if (dir) begin
      r = {w[14:5], 1'b0, w[4:0]};
    end else begin
      r = {1'b0, w[15:6], w[4:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/sscc_walker.sv =====
// Scanline walker: tracks pair and run counts and classifies each word.
module sscc_walker import sscc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [WordW-1:0]   word_i,
  input  logic               line_end_i,
  output logic               converted_o,
  output logic [StatusW-1:0] status_o
);

  phase_e           phase_q, phase_d;
  logic [WordW-1:0] pairs_q, pairs_d;
  logic [WordW-1:0] run_q, run_d;
  phase_e           phase_nx;
  logic [WordW-1:0] pairs_dec;
  logic [WordW-1:0] run_dec;
  logic             run_open;
  logic             pair_open;
  logic             line_clear;

  assign pairs_dec = pairs_q - 16'd1;
  assign run_dec   = run_q - 16'd1;

  // Advance the phase for the current word
  always_comb begin
    phase_nx = phase_q;
    pairs_d  = pairs_q;
    run_d    = run_q;
    case (phase_q)
      PhPairs: begin
        pairs_d  = word_i;
        phase_nx = (word_i == '0) ? PhTail : PhTrans;
      end
      PhTrans: begin
        phase_nx = PhIdxCnt;
      end
      PhIdxCnt: begin
        run_d    = word_i;
        phase_nx = (word_i == '0) ? PhColCnt : PhIdxSkip;
      end
      PhIdxSkip: begin
        run_d = run_dec;
        if (run_dec == '0) begin
          phase_nx = PhColCnt;
        end
      end
      PhColCnt: begin
        run_d = word_i;
        if (word_i == '0) begin
          pairs_d  = pairs_dec;
          phase_nx = (pairs_dec == '0) ? PhTail : PhTrans;
        end else begin
          phase_nx = PhColor;
        end
      end
      PhColor: begin
        run_d = run_dec;
        if (run_dec == '0) begin
          pairs_d  = pairs_dec;
          phase_nx = (pairs_dec == '0) ? PhTail : PhTrans;
        end
      end
      default: begin
        phase_nx = PhTail;
      end
    endcase
    phase_d = phase_nx;
    // Drop back to the start of a line on its last word
    if (line_end_i) begin
      phase_d = PhPairs;
      pairs_d = '0;
      run_d   = '0;
    end
  end

  // Classify the current word
  always_comb begin
    converted_o = (phase_q == PhColor);
    if (!line_end_i) begin
      status_o = StatMid;
    end else if (phase_nx == PhTail) begin
      status_o = StatDone;
    end else begin
      status_o = StatShort;
    end
  end

  // Hold state unless a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPairs;
      pairs_q <= '0;
      run_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pairs_q <= pairs_d;
      run_q   <= run_d;
    end
  end

  // Phase groups watched by the checks below
  assign run_open   = phase_q inside {PhIdxSkip, PhColor};
  assign pair_open  = phase_q inside {PhTrans, PhIdxCnt, PhColCnt, PhColor};
  assign line_clear = (phase_q == PhPairs) && (pairs_q == '0) && (run_q == '0);

`include "sprite_scanline_color_converter_assert.svh"

  `SSCC_ASSERT_NXT(a_line_end_clears, step_i && line_end_i, line_clear)
  `SSCC_ASSERT_IMP(a_run_nonzero, run_open, run_q != '0)
  `SSCC_ASSERT_IMP(a_pairs_nonzero, pair_open, pairs_q != '0)

endmodule

// ===== src/sscc_out_buf.sv =====
// Result register with a skid entry so the input side keeps moving.
module sscc_out_buf import sscc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q;
  logic    skid_valid_q;
  result_t main_q;
  result_t skid_q;
  logic    take;
  logic    push;

  assign in_stall_o  = skid_valid_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign take        = main_valid_q && !out_stall_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Control: main slot and skid slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || take) begin
      main_valid_q <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: refill main from skid first, else from the new request
  always_ff @(posedge clk_i) begin
    if (!main_valid_q || take) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
        if (push) begin
          skid_q <= in_data_i;
        end
      end else if (push) begin
        main_q <= in_data_i;
      end
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// ===== src/sprite_scanline_color_converter.sv =====
// A request's result is registered in the output buffer (main or skid slot) before it shows at the output.
// One request per cycle while in_stall_o is low; the walker updates its counts in a single step.
// A two-entry result buffer lets two requests wait before in_stall_o rises.
// Reset (rst_ni low, asynchronous) clears the line state, the buffer and direction to 565->555.
// Top level: sprite scanline color converter.
module sprite_scanline_color_converter import sscc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   word_i,
  input  logic               line_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   word_out_o,
  output logic               converted_o,
  output logic [StatusW-1:0] line_status_o
);

  logic               dir_q;
  logic               step;
  logic               conv;
  logic [StatusW-1:0] status;
  result_t            res;
  result_t            out_res;

  assign step = in_valid_i && !in_stall_o;

  // Direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  sscc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (word_i),
    .line_end_i  (line_end_i),
    .converted_o (conv),
    .status_o    (status)
  );

  // Build the result: convert only color words
  always_comb begin
    res.word      = conv ? conv_word(word_i, dir_q) : word_i;
    res.converted = conv;
    res.status    = status;
  end

  sscc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign word_out_o    = out_res.word;
  assign converted_o   = out_res.converted;
  assign line_status_o = out_res.status;

endmodule

// ===== tb/tb_sprite_scanline_color_converter.sv =====
// Self-checking testbench for the sprite scanline color converter.
module tb_sprite_scanline_color_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import sscc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned RandomItems = 250;

  // One scanline word offered to the block
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } scan_req_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid  = 1'b0;
  logic [WordW-1:0]   word_in   = '0;
  logic               last_in   = 1'b0;
  logic               out_stall = 1'b0;
  logic               long_hold = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [WordW-1:0]   word_out;
  logic               converted;
  logic [StatusW-1:0] line_status;

  scan_req_t   scan_req_q[$];
  result_t     line_results_q[$];

  // Line walker mirror
  phase_e      walk_phase = PhPairs;
  logic [15:0] pairs_left = '0;
  logic [15:0] run_left   = '0;
  logic        conv_dir   = 1'b0;

  int unsigned tx_gap = 0, tx_calm = 0;
  int unsigned rx_stall_left = 0, rx_calm = 0, rx_hold_left = 0;
  int unsigned n_req = 0, n_res = 0, n_err = 0, n_cycles = 0, n_pushed = 0;
  int unsigned n_lines = 0, n_conv = 0, n_done = 0, n_short = 0, n_cfg = 0;

  sprite_scanline_color_converter i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .word_i        (word_in),
    .line_end_i    (last_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .word_out_o    (word_out),
    .converted_o   (converted),
    .line_status_o (line_status)
  );

  always #10 clk = ~clk;

  // Close one transparent/index/color pair
  function automatic void close_pair();
    pairs_left = pairs_left - 16'd1;
    walk_phase = (pairs_left == '0) ? PhTail : PhTrans;
  endfunction

  // Advance the line walker by one word and return the expected result
  function automatic result_t walk_word(input logic [WordW-1:0] w, input logic last);
    result_t r;
    r.word      = w;
    r.converted = 1'b0;
    r.status    = StatMid;
    case (walk_phase)
      PhPairs: begin
        pairs_left = w;
        walk_phase = (w == '0) ? PhTail : PhTrans;
      end
      PhTrans: walk_phase = PhIdxCnt;
      PhIdxCnt: begin
        run_left   = w;
        walk_phase = (w == '0) ? PhColCnt : PhIdxSkip;
      end
      PhIdxSkip: begin
        run_left = run_left - 16'd1;
        if (run_left == '0) walk_phase = PhColCnt;
      end
      PhColCnt: begin
        run_left = w;
        if (w == '0) close_pair();
        else walk_phase = PhColor;
      end
      PhColor: begin
        // 555 to 565 drops the top bit; 565 to 555 drops the green LSB
        r.word = conv_dir ? (((w << 1) & 16'hFFC0) | (w & 16'h001F))
                          : (((w >> 1) & 16'h7FE0) | (w & 16'h001F));
        r.converted = 1'b1;
        n_conv++;
        run_left = run_left - 16'd1;
        if (run_left == '0) close_pair();
      end
      default: walk_phase = PhTail;
    endcase
    if (last) begin
      r.status = (walk_phase == PhTail) ? StatDone : StatShort;
      if (walk_phase == PhTail) n_done++;
      else n_short++;
      walk_phase = PhPairs;
      pairs_left = '0;
      run_left   = '0;
    end
    return r;
  endfunction

  // Mostly short idle stretches, a few long ones
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
  endfunction

  // Driver: predict accepted requests, then hold, idle or offer the next one
  always @(posedge clk) begin : drive_requests
    scan_req_t req;
    logic      accepted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) conv_dir = cfg_wdata;
      accepted = in_valid && !in_stall;
      if (accepted) begin
        line_results_q.push_back(walk_word(word_in, last_in));
        n_req++;
      end
      if (in_valid && !accepted) begin
        // hold the stalled request
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (scan_req_q.size() != 0) begin
        req = scan_req_q.pop_front();
        in_valid <= 1'b1;
        word_in  <= req.word;
        last_in  <= req.last;
        if (tx_calm > 0) tx_calm--;
        else if ($urandom_range(0, 63) == 0) tx_calm = $urandom_range(40, 150);
        if (long_hold || tx_calm > 0 || $urandom_range(0, 1) == 0) tx_gap = 0;
        else tx_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result, then drive the receiver stall
  always @(posedge clk) begin : check_results
    result_t want;
    logic    stall_nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_res++;
        if (line_results_q.size() == 0) begin
          n_err++;
          $display("%0t: result with nothing expected: word_out %h converted %0d status %0d",
                   $time, word_out, converted, line_status);
        end else begin
          want = line_results_q.pop_front();
          if (word_out !== want.word || converted !== want.converted
              || line_status !== want.status) begin
            n_err++;
            if (n_err < 30) begin
              if (word_out !== want.word)
                $display("%0t: word_out mismatch: expected %h, actual %h",
                         $time, want.word, word_out);
              if (converted !== want.converted)
                $display("%0t: converted mismatch: expected %0d, actual %0d",
                         $time, want.converted, converted);
              if (line_status !== want.status)
                $display("%0t: line_status mismatch: expected %0d, actual %0d",
                         $time, want.status, line_status);
            end
          end
        end
        // hold off for a long stretch twice so the block backs up
        if (n_res == 150 || n_res == 500) rx_hold_left = LongHold;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        stall_nxt = 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = 1'b0;
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 63) == 0) rx_calm = $urandom_range(40, 150);
        else if ($urandom_range(0, 3) == 0) rx_stall_left = idle_len();
      end
      out_stall <= stall_nxt;
      long_hold <= (rx_hold_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, line_results_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(input logic [WordW-1:0] w, input logic last);
    scan_req_t req;
    req.word = w;
    req.last = last;
    scan_req_q.push_back(req);
    n_pushed++;
  endtask

  // Wait until every request has been sent and every result has come back
  task automatic wait_idle();
    while (scan_req_q.size() != 0 || in_valid || line_results_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dir(input logic d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  // Build one coded line: mostly well formed, some cut short, some noise
  task automatic add_random_line();
    logic [WordW-1:0] words[$];
    int unsigned      pick, pairs, cnt, len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      len = $urandom_range(1, 6);
      repeat (len) words.push_back(WordW'($urandom));
    end else begin
      pairs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      words.push_back(WordW'(pairs));
      repeat (pairs) begin
        words.push_back(WordW'($urandom));
        cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        words.push_back(WordW'(cnt));
        repeat (cnt) words.push_back(WordW'($urandom));
        cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        words.push_back(WordW'(cnt));
        repeat (cnt) words.push_back(WordW'($urandom));
      end
      // trailing words after the last pair
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) words.push_back(WordW'($urandom));
      // end the line early
      if (pick < 30 && words.size() > 1) begin
        len = $urandom_range(1, words.size() - 1);
        while (words.size() > len) void'(words.pop_back());
      end
    end
    foreach (words[i]) send(words[i], i == words.size() - 1);
    n_lines++;
  endtask

  task automatic random_phase();
    int unsigned target;
    target = n_pushed + RandomItems;
    while (n_pushed < target) add_random_line();
  endtask

  initial begin : run_test
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_dir(1'b0);
    // zero pair count: complete at once
    send(16'd0, 1'b1);
    // huge pair count, line ends early
    send(16'hFFFF, 1'b0);
    send(16'd3, 1'b1);
    // zero index and color runs, then one color word
    send(16'd2, 1'b0);
    send(16'd7, 1'b0);
    send(16'd0, 1'b0);
    send(16'd0, 1'b0);
    send(16'd9, 1'b0);
    send(16'd0, 1'b0);
    send(16'd1, 1'b0);
    send(16'hFFFF, 1'b1);
    wait_idle();

    write_dir(1'b1);
    // full pair with index words, color words with the top bit set, a trailing word
    send(16'd1, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'd2, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'h0000, 1'b0);
    send(16'd3, 1'b0);
    send(16'hFFFF, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h0000, 1'b0);
    send(16'h5555, 1'b1);
    random_phase();
    wait_idle();

    write_dir(1'b0);
    random_phase();
    wait_idle();

    write_dir(1'b1);
    random_phase();
    wait_idle();
    repeat (6) @(posedge clk);

    n_err += line_results_q.size();
    $display("Covered %0d requests over %0d random lines plus directed ones, %0d results checked.",
             n_req, n_lines, n_res);
    $display("%0d color words converted, %0d lines complete, %0d cut short, %0d direction writes.",
             n_conv, n_done, n_short, n_cfg);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sscc_pkg.sv
src/sscc_walker.sv
src/sscc_out_buf.sv
src/sprite_scanline_color_converter.sv
tb/tb_sprite_scanline_color_converter.sv
